// ----- rtl/hpt_pkg.sv -----
// shared constants and types for the homogeneous point transform
package hpt_pkg;
  localparam int FRAC_BITS = 16;
  localparam int NUM_REGS = 8;
  localparam int REG_W = 64;
  localparam int IDX_W = 3;
  // column sums: four 64-bit products plus carry room, reduced by FRAC_BITS
  localparam int SUM_W = 67;
  localparam int COL_W = SUM_W - FRAC_BITS;
  // divide operands
  localparam int NUM_W = COL_W + FRAC_BITS;
  localparam int QUO_W = NUM_W;
  localparam int DIV_STEPS = NUM_W;
  localparam int QUO_MAX = 32'h7FFF_FFFF;

  typedef logic signed [31:0] entry_t;
  typedef entry_t mat_t [4][4];

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic [NUM_W-1:0] den;
    logic             neg_x;
    logic             neg_y;
    logic             neg_z;
    logic             wz;
  } div_ctl_t;
endpackage

// ----- rtl/hpt_matmul.sv -----
// product and column sum stages: c[j] = floor(sum p / 2^FRAC_BITS)
module hpt_matmul (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic signed [31:0]                     x,
  input  logic signed [31:0]                     y,
  input  logic signed [31:0]                     z,
  input  hpt_pkg::mat_t                          m,
  output logic                                   out_valid,
  output logic signed [hpt_pkg::COL_W-1:0]       col [4]
);
  logic signed [63:0] prod [4][4];
  logic               v1;
  logic signed [hpt_pkg::SUM_W-1:0] sum_c [4];

  // stage 1: twelve exact products plus the shifted fourth-row entries
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        prod[0][j] <= 64'(x * m[0][j]);
        prod[1][j] <= 64'(y * m[1][j]);
        prod[2][j] <= 64'(z * m[2][j]);
        prod[3][j] <= 64'(m[3][j]) <<< hpt_pkg::FRAC_BITS;
      end
    end
  end

  // stage 2: exact sums, arithmetic shift gives floor
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      sum_c[j] = hpt_pkg::SUM_W'(prod[0][j]) + hpt_pkg::SUM_W'(prod[1][j])
               + hpt_pkg::SUM_W'(prod[2][j]) + hpt_pkg::SUM_W'(prod[3][j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        col[j] <= hpt_pkg::COL_W'(sum_c[j] >>> hpt_pkg::FRAC_BITS);
      end
    end
  end
endmodule

// ----- rtl/hpt_div.sv -----
// pipelined restoring divider: one quotient bit per stage, three lanes share the divisor
module hpt_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [hpt_pkg::COL_W-1:0]    col [4],
  output logic                                out_valid,
  output logic [95:0]                         res,
  output logic                                wz
);
  localparam int N = hpt_pkg::DIV_STEPS;
  localparam int NW = hpt_pkg::NUM_W;

  hpt_pkg::div_lane_t lane [N+1][3];
  hpt_pkg::div_ctl_t  ctl  [N+1];
  logic               vld  [N+1];
  hpt_pkg::div_lane_t nxt  [N][3];
  logic [NW-1:0]      mag  [3];
  logic [NW-1:0]      wmag;
  logic [NW:0]        trial [N][3];
  logic [31:0]        sat  [3];
  logic [NW-1:0]      q;

  // stage 0: magnitudes and signs
  always_comb begin
    wmag = col[3][hpt_pkg::COL_W-1] ? NW'(-col[3]) : NW'(col[3]);
    for (int k = 0; k < 3; k++) begin
      mag[k] = col[k][hpt_pkg::COL_W-1] ? NW'(-col[k]) : NW'(col[k]);
      mag[k] = mag[k] << hpt_pkg::FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl[0].den   <= wmag;
      ctl[0].wz    <= (col[3] == '0);
      ctl[0].neg_x <= col[0][hpt_pkg::COL_W-1] ^ col[3][hpt_pkg::COL_W-1];
      ctl[0].neg_y <= col[1][hpt_pkg::COL_W-1] ^ col[3][hpt_pkg::COL_W-1];
      ctl[0].neg_z <= col[2][hpt_pkg::COL_W-1] ^ col[3][hpt_pkg::COL_W-1];
      for (int k = 0; k < 3; k++) begin
        lane[0][k].rem <= '0;
        lane[0][k].quo <= mag[k];
      end
    end
  end

  // quotient stages, dividend shifts in from quo
  always_comb begin
    for (int s = 0; s < N; s++) begin
      for (int k = 0; k < 3; k++) begin
        trial[s][k] = {lane[s][k].rem, lane[s][k].quo[NW-1]} - {1'b0, ctl[s].den};
        if (!trial[s][k][NW]) begin
          nxt[s][k].rem = trial[s][k][NW-1:0];
          nxt[s][k].quo = {lane[s][k].quo[NW-2:0], 1'b1};
        end else begin
          nxt[s][k].rem = {lane[s][k].rem[NW-2:0], lane[s][k].quo[NW-1]};
          nxt[s][k].quo = {lane[s][k].quo[NW-2:0], 1'b0};
        end
      end
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ctl[s+1] <= ctl[s];
        for (int k = 0; k < 3; k++) begin
          lane[s+1][k] <= nxt[s][k];
        end
      end
    end
  end

  // saturate and sign
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic neg;
      neg = (k == 0) ? ctl[N].neg_x : (k == 1) ? ctl[N].neg_y : ctl[N].neg_z;
      q = lane[N][k].quo;
      if (ctl[N].wz) begin
        sat[k] = '0;
      end else if (neg) begin
        sat[k] = (q >= NW'(32'h8000_0000)) ? 32'h8000_0000 : 32'(-q);
      end else begin
        sat[k] = (q > NW'(hpt_pkg::QUO_MAX)) ? 32'(hpt_pkg::QUO_MAX) : q[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= {sat[2], sat[1], sat[0]};
      wz  <= ctl[N].wz;
    end
  end
endmodule

// ----- rtl/homogeneous_point_transform_top.sv -----
// top level: config registers, matrix pipeline, divide pipeline, stall control
//  channel  dir  tdata (low bit up)                 tuser
//  s_axis   in   in_x, in_y, in_z (96 bits)         -
//  m_axis   out  out_x, out_y, out_z (96 bits)      w_zero
//  cfg      in   cfg_we, cfg_index[2:0], cfg_data[63:0]
// one word per cycle while m_axis does not stall; pipe depth is set by the
// one-bit-per-stage divider. the whole pipe holds when m_axis stalls, so
// s_axis_tready follows m_axis_tready or an empty output slot.
// reset loads the identity matrix and empties the pipe.
module homogeneous_point_transform_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // in_x, in_y, in_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // out_x, out_y, out_z
  output logic        m_axis_tuser,   // w_zero
  input  logic        cfg_we,
  input  logic [hpt_pkg::IDX_W-1:0] cfg_index,
  input  logic [hpt_pkg::REG_W-1:0] cfg_data
);
  logic [hpt_pkg::REG_W-1:0] regs [hpt_pkg::NUM_REGS];
  hpt_pkg::mat_t m;
  logic en;
  logic mv;
  logic signed [hpt_pkg::COL_W-1:0] col [4];

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      regs[0] <= 64'd1 << hpt_pkg::FRAC_BITS;
      regs[1] <= '0;
      regs[2] <= 64'd1 << (hpt_pkg::FRAC_BITS + 32);
      regs[3] <= '0;
      regs[4] <= '0;
      regs[5] <= 64'd1 << hpt_pkg::FRAC_BITS;
      regs[6] <= '0;
      regs[7] <= 64'd1 << (hpt_pkg::FRAC_BITS + 32);
    end else if (cfg_we) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  // unpack matrix entries
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        m[r][c] = (c % 2 == 1) ? regs[r*2 + c/2][63:32] : regs[r*2 + c/2][31:0];
      end
    end
  end

  // pipe advances unless a result waits unaccepted
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  hpt_matmul u_matmul (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_axis_tvalid),
    .x(s_axis_tdata[31:0]), .y(s_axis_tdata[63:32]), .z(s_axis_tdata[95:64]),
    .m(m), .out_valid(mv), .col(col)
  );

  hpt_div u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(mv), .col(col),
    .out_valid(m_axis_tvalid), .res(m_axis_tdata), .wz(m_axis_tuser)
  );

  // assertions
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");
  a_wz: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("zero w with nonzero coordinates");
endmodule
